// ===== hw/rtl/rgef_pkg.sv =====
package rgef_pkg;

    localparam int unsigned AddrWidth = 5;
    localparam int unsigned DataWidth = 32;

    localparam logic [2:0] RegZoneMin  = 3'd0;
    localparam logic [2:0] RegZoneMax  = 3'd1;
    localparam logic [2:0] RegHold     = 3'd2;
    localparam logic [2:0] RegDebounce = 3'd3;
    localparam logic [2:0] RegConfMin  = 3'd4;
    localparam logic [2:0] RegFallback = 3'd5;

    localparam logic [15:0] ZoneMinReset  = 16'd5;
    localparam logic [15:0] ZoneMaxReset  = 16'd30;
    localparam logic [15:0] HoldReset     = 16'd800;
    localparam logic [15:0] DebounceReset = 16'd1000;
    localparam logic [7:0]  ConfMinReset  = 8'd179;
    localparam logic        FallbackReset = 1'b1;

    localparam logic [2:0] GestNone  = 3'd0;
    localparam logic [2:0] GestNext  = 3'd1;
    localparam logic [2:0] GestPrev  = 3'd2;
    localparam logic [2:0] GestHover = 3'd3;

    localparam logic [31:0] HoverSpacingMs = 32'd400;
    localparam logic [15:0] VolOffsetCm    = 16'd10;
    localparam logic [15:0] VolScale       = 16'd4;
    localparam logic [15:0] VolMax         = 16'd100;
    localparam logic [15:0] VolSatSteps    = 16'((100 + 4 - 1) / 4);

    typedef enum logic [1:0] {
        KIND_NEXT = 2'd0,
        KIND_PREV = 2'd1,
        KIND_VOL  = 2'd2
    } event_kind_t;

    function automatic logic [15:0] volume_of(input logic [15:0] d);
        logic [15:0] v;
        logic [15:0] scaled;
        v = d - VolOffsetCm;
        scaled = v * VolScale;
        if (d <= VolOffsetCm) begin
            volume_of = 16'd0;
        end else if (v >= VolSatSteps) begin
            volume_of = VolMax;
        end else begin
            volume_of = scaled;
        end
    endfunction

endpackage

// ===== hw/rtl/radar_gesture_event_filter.sv =====
// Turns radar reports into media events, at most one per report beat. A confident
// classifier verdict gives next, prev or volume, each rate limited on the report
// timestamps; otherwise, with the fallback on, a distance held in the near zone
// for hold_ms gives one next and re-arms once the distance leaves the zone. One
// report is taken every clock cycle: the decision is a single pass of compares
// and 32-bit timestamp subtractions between the state registers and the result
// register, and a new report is taken while a result waits as long as the sink
// takes that result in the same cycle. Each result appears in the cycle after its
// report. Configuration sits on an APB port, registers at byte offset 4*index.
module radar_gesture_event_filter
    import rgef_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AddrWidth-1:0] paddr,
    input  logic [DataWidth-1:0] pwdata,
    output logic [DataWidth-1:0] prdata,
    output logic                 pready,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [31:0]          s_time_ms,
    input  logic [15:0]          s_reported_dist,
    input  logic [15:0]          s_nearest_dist,
    input  logic                 s_ai_present,
    input  logic [2:0]           s_cls_gesture,
    input  logic [7:0]           s_cls_conf,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_event_kind,
    output logic [15:0]          m_event_value
);

    logic [15:0] zone_min_reg;
    logic [15:0] zone_max_reg;
    logic [15:0] hold_reg;
    logic [15:0] debounce_reg;
    logic [7:0]  conf_min_reg;
    logic        fallback_reg;

    logic        zone_armed_reg, zone_armed_next;
    logic [31:0] zone_enter_reg, zone_enter_next;
    logic [31:0] last_next_reg, last_next_next;
    logic [31:0] last_prev_reg, last_prev_next;
    logic [31:0] last_hover_reg, last_hover_next;

    logic        out_valid_reg;
    event_kind_t out_kind_reg, kind;
    logic [15:0] out_value_reg, value;
    logic        fire;

    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic        s_accept;
    logic [15:0] d;
    logic        ai_hit;
    logic        in_zone;
    logic [31:0] el_next, el_prev, el_hover, el_zone;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[AddrWidth-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zone_min_reg <= ZoneMinReset;
            zone_max_reg <= ZoneMaxReset;
            hold_reg     <= HoldReset;
            debounce_reg <= DebounceReset;
            conf_min_reg <= ConfMinReset;
            fallback_reg <= FallbackReset;
        end else if (cfg_write) begin
            unique case (cfg_index)
                RegZoneMin:  zone_min_reg <= pwdata[15:0];
                RegZoneMax:  zone_max_reg <= pwdata[15:0];
                RegHold:     hold_reg     <= pwdata[15:0];
                RegDebounce: debounce_reg <= pwdata[15:0];
                RegConfMin:  conf_min_reg <= pwdata[7:0];
                RegFallback: fallback_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_index)
            RegZoneMin:  prdata = {16'd0, zone_min_reg};
            RegZoneMax:  prdata = {16'd0, zone_max_reg};
            RegHold:     prdata = {16'd0, hold_reg};
            RegDebounce: prdata = {16'd0, debounce_reg};
            RegConfMin:  prdata = {24'd0, conf_min_reg};
            RegFallback: prdata = {31'd0, fallback_reg};
            default:     prdata = '0;
        endcase
    end

    assign s_ready  = !out_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    assign d        = (s_reported_dist != 16'd0) ? s_reported_dist : s_nearest_dist;
    assign ai_hit   = s_ai_present && (s_cls_conf >= conf_min_reg)
                      && (s_cls_gesture != GestNone);
    assign in_zone  = (d != 16'd0) && (d >= zone_min_reg) && (d <= zone_max_reg);
    assign el_next  = s_time_ms - last_next_reg;
    assign el_prev  = s_time_ms - last_prev_reg;
    assign el_hover = s_time_ms - last_hover_reg;
    assign el_zone  = s_time_ms - zone_enter_reg;

    always_comb begin
        zone_armed_next = zone_armed_reg;
        zone_enter_next = zone_enter_reg;
        last_next_next  = last_next_reg;
        last_prev_next  = last_prev_reg;
        last_hover_next = last_hover_reg;
        fire  = 1'b0;
        kind  = KIND_NEXT;
        value = d;
        if (ai_hit) begin
            unique case (s_cls_gesture)
                GestNext: begin
                    if (el_next >= {16'd0, debounce_reg}) begin
                        last_next_next  = s_time_ms;
                        zone_armed_next = 1'b0;
                        zone_enter_next = '0;
                        fire = 1'b1;
                    end
                end
                GestPrev: begin
                    if (el_prev >= {16'd0, debounce_reg}) begin
                        last_prev_next = s_time_ms;
                        fire = 1'b1;
                        kind = KIND_PREV;
                    end
                end
                GestHover: begin
                    if (el_hover >= HoverSpacingMs) begin
                        last_hover_next = s_time_ms;
                        fire  = 1'b1;
                        kind  = KIND_VOL;
                        value = volume_of(d);
                    end
                end
                default: ;
            endcase
        end else if (fallback_reg) begin
            priority if (!in_zone) begin
                zone_armed_next = 1'b1;
                zone_enter_next = '0;
            end else if (!zone_armed_reg) begin
            end else if (zone_enter_reg == 32'd0) begin
                zone_enter_next = s_time_ms;
            end else if (el_zone >= {16'd0, hold_reg}) begin
                zone_armed_next = 1'b0;
                zone_enter_next = '0;
                if (el_next >= {16'd0, debounce_reg}) begin
                    last_next_next = s_time_ms;
                    fire = 1'b1;
                end
            end else begin
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zone_armed_reg <= 1'b1;
            zone_enter_reg <= '0;
            last_next_reg  <= '0;
            last_prev_reg  <= '0;
            last_hover_reg <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (s_accept) begin
                zone_armed_reg <= zone_armed_next;
                zone_enter_reg <= zone_enter_next;
                last_next_reg  <= last_next_next;
                last_prev_reg  <= last_prev_next;
                last_hover_reg <= last_hover_next;
                out_valid_reg  <= fire;
            end else if (m_ready) begin
                out_valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && fire) begin
            out_kind_reg  <= kind;
            out_value_reg <= value;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_event_kind  = out_kind_reg;
    assign m_event_value = out_value_reg;

endmodule

// ===== hw/rtl/rgef_checker.sv =====
module rgef_checker
    import rgef_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_event_kind,
    input logic [15:0] m_event_value
);

    // result beat holds while stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_kind) && $stable(m_event_value))
        else $error("result beat changed while stalled");

    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // input side never blocked by an empty or draining result register
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid || m_ready |-> s_ready)
        else $error("input stalled with room for a result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_event_kind == KIND_NEXT) || (m_event_kind == KIND_PREV)
                    || ((m_event_kind == KIND_VOL) && (m_event_value <= VolMax)))
        else $error("bad event kind or volume out of range");

endmodule

bind radar_gesture_event_filter rgef_checker u_rgef_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_event_kind  (m_event_kind),
    .m_event_value (m_event_value)
);

// ===== dv/tb_radar_gesture_event_filter.sv =====
module tb_radar_gesture_event_filter
    import rgef_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SinkHoldCycles = 150;
    localparam int unsigned WatchdogLimit  = 1000;
    localparam int unsigned DrainCycles    = 3;
    localparam logic [2:0]  RegSpareA      = 3'd6;
    localparam logic [2:0]  RegSpareB      = 3'd7;
    localparam logic [2:0]  GestOther      = 3'd4;
    localparam logic [2:0]  GestLast       = 3'd7;

    typedef struct packed {
        logic [31:0] time_ms;
        logic [15:0] reported_dist;
        logic [15:0] nearest_dist;
        logic        ai_present;
        logic [2:0]  cls_gesture;
        logic [7:0]  cls_conf;
    } radar_report_t;

    typedef struct packed {
        event_kind_t kind;
        logic [15:0] value;
    } media_event_t;

    logic                 aclk            = 1'b0;
    logic                 aresetn         = 1'b0;
    logic                 psel            = 1'b0;
    logic                 penable         = 1'b0;
    logic                 pwrite          = 1'b0;
    logic [AddrWidth-1:0] paddr           = '0;
    logic [DataWidth-1:0] pwdata          = '0;
    logic [DataWidth-1:0] prdata;
    logic                 pready;
    logic                 s_valid         = 1'b0;
    logic                 s_ready;
    logic [31:0]          s_time_ms       = '0;
    logic [15:0]          s_reported_dist = '0;
    logic [15:0]          s_nearest_dist  = '0;
    logic                 s_ai_present    = 1'b0;
    logic [2:0]           s_cls_gesture   = '0;
    logic [7:0]           s_cls_conf      = '0;
    logic                 m_valid;
    logic                 m_ready         = 1'b0;
    logic [1:0]           m_event_kind;
    logic [15:0]          m_event_value;

    // register shadows
    logic [15:0] zone_min_cfg = ZoneMinReset;
    logic [15:0] zone_max_cfg = ZoneMaxReset;
    logic [15:0] hold_cfg     = HoldReset;
    logic [15:0] debounce_cfg = DebounceReset;
    logic [7:0]  conf_min_cfg = ConfMinReset;
    logic        fallback_cfg = FallbackReset;

    // filter state
    logic        zone_ready    = 1'b1;
    logic [31:0] hold_start_ms = '0;
    logic [31:0] last_next_ms  = '0;
    logic [31:0] last_prev_ms  = '0;
    logic [31:0] last_hover_ms = '0;

    media_event_t pending_events[$];
    int unsigned  error_count   = 0;
    int unsigned  stall_cycles  = 0;
    logic [31:0]  ms_clock      = '0;
    bit           near_zone_run = 1'b0;
    bit           no_idle       = 1'b0;
    bit           sink_hold_req = 1'b0;

    radar_gesture_event_filter DUT (.*);

    initial forever #4 aclk = ~aclk;

    function automatic logic [31:0] ms_since(input logic [31:0] now, input logic [31:0] since);
        return now - since;
    endfunction

    function automatic int unsigned idle_len();
        return ($urandom_range(9) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3);
    endfunction

    function automatic radar_report_t make_report(input logic [31:0] t, input logic [15:0] rep,
                                                  input logic [15:0] near, input logic present,
                                                  input logic [2:0] gest, input logic [7:0] conf);
        return '{t, rep, near, present, gest, conf};
    endfunction

    function automatic void predict_media_event(input radar_report_t r);
        logic [15:0]  dist_cm;
        logic         confident;
        logic         in_zone;
        logic [31:0]  scaled;
        media_event_t ev;
        bit           fire;
        fire = 1'b0;
        dist_cm = (r.reported_dist != 16'd0) ? r.reported_dist : r.nearest_dist;
        confident = r.ai_present && (r.cls_conf >= conf_min_cfg) &&
                    (r.cls_gesture != GestNone);
        ev.kind = KIND_NEXT;
        ev.value = dist_cm;
        if (confident) begin
            if (r.cls_gesture == GestNext) begin
                if (ms_since(r.time_ms, last_next_ms) >= 32'(debounce_cfg)) begin
                    last_next_ms = r.time_ms;
                    zone_ready = 1'b0;
                    hold_start_ms = '0;
                    fire = 1'b1;
                end
            end else if (r.cls_gesture == GestPrev) begin
                if (ms_since(r.time_ms, last_prev_ms) >= 32'(debounce_cfg)) begin
                    last_prev_ms = r.time_ms;
                    ev.kind = KIND_PREV;
                    fire = 1'b1;
                end
            end else if (r.cls_gesture == GestHover) begin
                if (ms_since(r.time_ms, last_hover_ms) >= HoverSpacingMs) begin
                    last_hover_ms = r.time_ms;
                    scaled = (dist_cm > VolOffsetCm) ?
                             32'(dist_cm - VolOffsetCm) * 32'(VolScale) : 32'd0;
                    ev.kind = KIND_VOL;
                    ev.value = (scaled > 32'(VolMax)) ? VolMax : scaled[15:0];
                    fire = 1'b1;
                end
            end
        end else if (fallback_cfg) begin
            in_zone = (dist_cm != 16'd0) && (dist_cm >= zone_min_cfg) &&
                      (dist_cm <= zone_max_cfg);
            if (!in_zone) begin
                zone_ready = 1'b1;
                hold_start_ms = '0;
            end else if (zone_ready) begin
                if (hold_start_ms == 32'd0) begin
                    hold_start_ms = r.time_ms;
                end else if (ms_since(r.time_ms, hold_start_ms) >= 32'(hold_cfg)) begin
                    zone_ready = 1'b0;
                    hold_start_ms = '0;
                    if (ms_since(r.time_ms, last_next_ms) >= 32'(debounce_cfg)) begin
                        last_next_ms = r.time_ms;
                        fire = 1'b1;
                    end
                end
            end
        end
        if (fire) pending_events.push_back(ev);
    endfunction

    function automatic radar_report_t session_report();
        radar_report_t r;
        logic [15:0]   dist_cm;
        int unsigned   pick;
        pick = $urandom_range(99);
        if (pick < 3) begin
            ms_clock += $urandom_range(30000, 70000);
        end else if (pick < 10) begin
            ms_clock += $urandom_range(1000, 3000);
        end else if (pick >= 15) begin
            ms_clock += $urandom_range(1, 250);
        end
        r.time_ms = ms_clock;
        if ($urandom_range(99) < 15) near_zone_run = !near_zone_run;
        if (near_zone_run && zone_min_cfg <= zone_max_cfg && $urandom_range(9) != 0) begin
            dist_cm = 16'($urandom_range(zone_max_cfg, zone_min_cfg));
        end else begin
            case ($urandom_range(2))
                0: dist_cm = 16'd0;
                1: dist_cm = 16'($urandom_range(0, 120));
                default: dist_cm = 16'($urandom);
            endcase
        end
        if ($urandom_range(9) < 7) begin
            r.reported_dist = dist_cm;
            r.nearest_dist = 16'($urandom);
        end else begin
            r.reported_dist = 16'd0;
            r.nearest_dist = dist_cm;
        end
        r.ai_present = 1'($urandom);
        r.cls_gesture = 3'($urandom_range(0, 7));
        r.cls_conf = 8'($urandom);
        if ($urandom_range(9) < 3) begin
            r.ai_present = 1'b1;
            r.cls_conf = 8'($urandom_range(255, conf_min_cfg));
            r.cls_gesture = ($urandom_range(9) < 8) ? 3'($urandom_range(GestHover, GestNext)) :
                                                      3'($urandom_range(GestLast, GestOther));
        end else begin
            case ($urandom_range(2))
                0: r.ai_present = 1'b0;
                1: r.cls_gesture = GestNone;
                default: begin
                    if (conf_min_cfg == 8'd0) r.ai_present = 1'b0;
                    else r.cls_conf = 8'($urandom_range(conf_min_cfg - 1, 0));
                end
            endcase
        end
        return r;
    endfunction

    task automatic send_report(input radar_report_t r);
        int unsigned gap;
        s_valid <= 1'b1;
        s_time_ms <= r.time_ms;
        s_reported_dist <= r.reported_dist;
        s_nearest_dist <= r.nearest_dist;
        s_ai_present <= r.ai_present;
        s_cls_gesture <= r.cls_gesture;
        s_cls_conf <= r.cls_conf;
        do @(posedge aclk); while (!s_ready);
        gap = (no_idle || $urandom_range(2) != 0) ? 0 : idle_len();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= AddrWidth'({idx, 2'b00});
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            RegZoneMin:  zone_min_cfg = data[15:0];
            RegZoneMax:  zone_max_cfg = data[15:0];
            RegHold:     hold_cfg = data[15:0];
            RegDebounce: debounce_cfg = data[15:0];
            RegConfMin:  conf_min_cfg = data[7:0];
            RegFallback: fallback_cfg = data[0];
            default: ;
        endcase
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apply_setting(input logic [15:0] zmin, zmax, hold, deb,
                                 input logic [7:0] conf, input logic fb);
        wait_drained();
        write_reg(RegZoneMin, {16'($urandom), zmin});
        write_reg(RegZoneMax, {16'($urandom), zmax});
        write_reg(RegHold, {16'($urandom), hold});
        write_reg(RegDebounce, {16'($urandom), deb});
        write_reg(RegConfMin, {24'($urandom), conf});
        write_reg(RegFallback, {31'($urandom), fb});
    endtask

    task automatic run_sessions(input int unsigned count, input int unsigned noise_pct);
        radar_report_t r;
        repeat (count) begin
            if ($urandom_range(99) < noise_pct) r = {$urandom, $urandom, 12'($urandom)};
            else r = session_report();
            send_report(r);
        end
    endtask

    task automatic test_directed_cases();
        // hold starting at time zero, debounced hold, nearest fallback
        send_report(make_report(32'd0, 16'd10, 16'd0, 1'b0, GestNone, 8'd0));
        send_report(make_report(32'd100, 16'd10, 16'd0, 1'b0, GestNone, 8'd0));
        send_report(make_report(32'd900, 16'd10, 16'd0, 1'b0, GestNone, 8'd0));
        send_report(make_report(32'd950, 16'd10, 16'd0, 1'b0, GestNone, 8'd0));
        send_report(make_report(32'd960, 16'd0, 16'd0, 1'b0, GestNone, 8'd0));
        send_report(make_report(32'd1000, 16'd0, 16'd20, 1'b0, GestNone, 8'd0));
        send_report(make_report(32'd1799, 16'd0, 16'd20, 1'b0, GestNone, 8'd0));
        send_report(make_report(32'd1800, 16'd0, 16'd20, 1'b0, GestNone, 8'd0));
        send_report(make_report(32'd1900, 16'd31, 16'd0, 1'b0, GestNone, 8'd0));
        // classifier next and prev with debounce
        send_report(make_report(32'd1950, 16'hFFFF, 16'd0, 1'b1, GestNext, 8'hFF));
        send_report(make_report(32'd2800, 16'hFFFF, 16'd0, 1'b1, GestNext, ConfMinReset));
        send_report(make_report(32'd2800, 16'd0, 16'hFFFF, 1'b1, GestPrev, 8'hFF));
        send_report(make_report(32'd3000, 16'd40, 16'd0, 1'b1, GestPrev, 8'hFF));
        // hover volume clamping and spacing
        send_report(make_report(32'd3000, 16'd5, 16'd0, 1'b1, GestHover, 8'd200));
        send_report(make_report(32'd3399, 16'd20, 16'd0, 1'b1, GestHover, 8'd200));
        send_report(make_report(32'd3400, 16'd34, 16'd0, 1'b1, GestHover, 8'd200));
        send_report(make_report(32'd3800, 16'd35, 16'd0, 1'b1, GestHover, 8'd200));
        send_report(make_report(32'd4200, 16'd10, 16'd0, 1'b1, GestHover, 8'd200));
        send_report(make_report(32'd4600, 16'd11, 16'd0, 1'b1, GestHover, 8'd200));
        send_report(make_report(32'd5000, 16'hFFFF, 16'd0, 1'b1, GestHover, 8'd200));
        // other verdicts skip the fallback, weak verdicts fall through
        send_report(make_report(32'd5100, 16'd20, 16'd0, 1'b1, GestOther, 8'hFF));
        send_report(make_report(32'd5200, 16'd20, 16'd0, 1'b1, GestLast, 8'hFF));
        send_report(make_report(32'd5300, 16'd20, 16'd0, 1'b0, GestNext, 8'hFF));
        send_report(make_report(32'd5400, 16'd100, 16'd0, 1'b1, GestNext, 8'd178));
        send_report(make_report(32'd5500, 16'd5, 16'd0, 1'b1, GestNone, 8'hFF));
        send_report(make_report(32'd6300, 16'd30, 16'd0, 1'b1, GestNext, 8'd178));
        // timestamp wrap
        send_report(make_report(32'hFFFF_FF00, 16'd50, 16'd0, 1'b1, GestPrev, 8'hFF));
        send_report(make_report(32'h0000_0100, 16'd50, 16'd0, 1'b1, GestPrev, 8'hFF));
        ms_clock = 32'd10000;
    endtask

    task automatic test_config_extremes();
        apply_setting(16'd0, 16'hFFFF, 16'd0, 16'd0, 8'd0, 1'b1);
        run_sessions(30, 10);
        apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
        run_sessions(30, 10);
        apply_setting(16'd40, 16'd10, 16'd100, 16'd200, 8'd128, 1'b1);
        run_sessions(30, 10);
        apply_setting(ZoneMinReset, ZoneMaxReset, HoldReset, DebounceReset, ConfMinReset, 1'b0);
        run_sessions(30, 10);
        apply_setting(16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 1'b1);
        write_reg(RegSpareA, $urandom);
        write_reg(RegSpareB, $urandom);
        run_sessions(30, 10);
        apply_setting(ZoneMinReset, ZoneMaxReset, HoldReset, DebounceReset, ConfMinReset,
                      FallbackReset);
    endtask

    task automatic test_output_backpressure();
        radar_report_t r;
        sink_hold_req = 1'b1;
        no_idle = 1'b1;
        repeat (30) begin
            r = session_report();
            ms_clock += HoverSpacingMs;
            r.time_ms = ms_clock;
            r.ai_present = 1'b1;
            r.cls_gesture = GestHover;
            r.cls_conf = 8'hFF;
            send_report(r);
        end
        no_idle = 1'b0;
    endtask

    task automatic test_sender_pause();
        run_sessions(15, 0);
        wait_drained();
        run_sessions(15, 0);
    endtask

    task automatic test_random_sessions();
        for (int phase = 0; phase < 7; phase++) begin
            apply_setting(16'($urandom_range(0, 40)), 16'($urandom_range(0, 90)),
                          16'($urandom_range(0, 1500)), 16'($urandom_range(0, 2500)),
                          8'($urandom), 1'($urandom_range(3) != 0));
            if (phase == 3) ms_clock = 32'hFFFF_F000;
            no_idle = (phase % 3 == 2);
            run_sessions(50, 15);
        end
        no_idle = 1'b0;
    endtask

    // result sink
    initial begin
        @(posedge aclk);
        forever begin
            if (sink_hold_req) begin
                m_ready <= 1'b0;
                repeat (SinkHoldCycles) @(posedge aclk);
                sink_hold_req = 1'b0;
            end else if (!no_idle && $urandom_range(3) == 0) begin
                m_ready <= 1'b0;
                repeat (idle_len()) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    // result check first, then prediction for the report beat of this edge
    always @(posedge aclk) begin
        media_event_t exp_ev;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_events.size() == 0) begin
                    $error("unexpected event beat: event_kind %0d event_value %0d",
                           m_event_kind, m_event_value);
                    error_count++;
                end else begin
                    exp_ev = pending_events.pop_front();
                    if (m_event_kind !== exp_ev.kind) begin
                        $error("event_kind: expected %0d, got %0d", exp_ev.kind, m_event_kind);
                        error_count++;
                    end
                    if (m_event_value !== exp_ev.value) begin
                        $error("event_value: expected %0d, got %0d", exp_ev.value,
                               m_event_value);
                        error_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                predict_media_event({s_time_ms, s_reported_dist, s_nearest_dist, s_ai_present,
                                     s_cls_gesture, s_cls_conf});
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable && pready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WatchdogLimit) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_config_extremes();
        test_output_backpressure();
        test_sender_pause();
        test_random_sessions();
        wait_drained();
        if (pending_events.size() != 0) begin
            $error("%0d events never arrived", pending_events.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
